### rtl/tbh_pkg.sv
// shared widths and types for the triangle barycentric height block
package tbh_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int WSUM_W  = PROD_W + 1;
   localparam int QUO_W   = COORD_W + 2;
   localparam int SPLIT_W = QUO_W;
   localparam int PLO_W   = SPLIT_W + 1 + DIFF_W;
   localparam int PHI_W   = (WSUM_W - SPLIT_W) + DIFF_W;
   localparam int NUM_W   = WSUM_W + DIFF_W + 1;
   localparam int REM_W   = NUM_W - QUO_W;
   localparam int RES_W   = QUO_W + 2;
   localparam int DIV_CELLS = QUO_W;

   localparam logic signed [COORD_W-1:0] H_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] H_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] v1_x;
      logic signed [COORD_W-1:0] v1_h;
      logic signed [COORD_W-1:0] v1_z;
      logic signed [COORD_W-1:0] v2_x;
      logic signed [COORD_W-1:0] v2_h;
      logic signed [COORD_W-1:0] v2_z;
      logic signed [COORD_W-1:0] v3_x;
      logic signed [COORD_W-1:0] v3_h;
      logic signed [COORD_W-1:0] v3_z;
      logic signed [COORD_W-1:0] query_x;
      logic signed [COORD_W-1:0] query_z;
   } tri_in_type;

   typedef struct packed {
      logic [REM_W-1:0]          rem;
      logic [QUO_W-1:0]          ubits;
      logic [QUO_W-1:0]          quo;
      logic [REM_W-1:0]          dvs;
      logic signed [COORD_W-1:0] h3;
      logic                      neg;
      logic                      ovf;
      logic                      degenerate;
   } div_item_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] height;
      logic                      degenerate;
      logic                      saturated;
   } res_type;

endpackage

### rtl/tbh_front.sv
// determinant, weights, numerator and operand setup ahead of the divider chain
module tbh_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  tbh_pkg::tri_in_type  in_item,
   output logic                 out_valid,
   output tbh_pkg::div_item_type out_item
);
   import tbh_pkg::*;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff;

   logic signed [DIFF_W-1:0]  s1_a_ff, s1_b_ff, s1_c_ff, s1_e_ff, s1_dx_ff, s1_dz_ff;
   logic signed [DIFF_W-1:0]  s1_dh1_ff, s1_dh2_ff;
   logic signed [COORD_W-1:0] s1_h3_ff;

   logic signed [PROD_W-1:0]  s2_ae_ff, s2_bc_ff, s2_adx_ff, s2_bdz_ff, s2_cdx_ff, s2_edz_ff;
   logic signed [DIFF_W-1:0]  s2_dh1_ff, s2_dh2_ff;
   logic signed [COORD_W-1:0] s2_h3_ff;

   logic signed [WSUM_W-1:0]  s3_det_ff, s3_w1_ff, s3_w2_ff;
   logic signed [DIFF_W-1:0]  s3_dh1_ff, s3_dh2_ff;
   logic signed [COORD_W-1:0] s3_h3_ff;

   logic signed [PLO_W-1:0]   s4_p1l_ff, s4_p2l_ff;
   logic signed [PHI_W-1:0]   s4_p1h_ff, s4_p2h_ff;
   logic signed [WSUM_W-1:0]  s4_det_ff;
   logic signed [COORD_W-1:0] s4_h3_ff;

   logic signed [NUM_W-1:0]   s5_n1_ff, s5_n2_ff;
   logic signed [WSUM_W-1:0]  s5_det_ff;
   logic signed [COORD_W-1:0] s5_h3_ff;

   logic signed [NUM_W-1:0]   s6_num_ff;
   logic signed [WSUM_W-1:0]  s6_det_ff;
   logic                      s6_dgn_ff;
   logic signed [COORD_W-1:0] s6_h3_ff;

   logic [NUM_W-1:0]          s7_u_ff;
   logic [REM_W-1:0]          s7_v_ff;
   logic                      s7_neg_ff, s7_dgn_ff;
   logic signed [COORD_W-1:0] s7_h3_ff;

   div_item_type              s8_item_ff;
   div_item_type              s8_item_in;

   always_comb begin
      s8_item_in            = '0;
      s8_item_in.rem        = s7_u_ff[NUM_W-1:QUO_W];
      s8_item_in.ubits      = s7_u_ff[QUO_W-1:0];
      s8_item_in.dvs        = s7_v_ff;
      s8_item_in.h3         = s7_h3_ff;
      s8_item_in.neg        = s7_neg_ff;
      s8_item_in.ovf        = (s7_u_ff >= {s7_v_ff, {QUO_W{1'b0}}});
      s8_item_in.degenerate = s7_dgn_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // edge vectors relative to vertex 3
         s1_a_ff   <= DIFF_W'(in_item.v2_z) - DIFF_W'(in_item.v3_z);
         s1_b_ff   <= DIFF_W'(in_item.v3_x) - DIFF_W'(in_item.v2_x);
         s1_c_ff   <= DIFF_W'(in_item.v3_z) - DIFF_W'(in_item.v1_z);
         s1_e_ff   <= DIFF_W'(in_item.v1_x) - DIFF_W'(in_item.v3_x);
         s1_dx_ff  <= DIFF_W'(in_item.query_x) - DIFF_W'(in_item.v3_x);
         s1_dz_ff  <= DIFF_W'(in_item.query_z) - DIFF_W'(in_item.v3_z);
         s1_dh1_ff <= DIFF_W'(in_item.v1_h) - DIFF_W'(in_item.v3_h);
         s1_dh2_ff <= DIFF_W'(in_item.v2_h) - DIFF_W'(in_item.v3_h);
         s1_h3_ff  <= in_item.v3_h;

         s2_ae_ff  <= s1_a_ff * s1_e_ff;
         s2_bc_ff  <= s1_b_ff * s1_c_ff;
         s2_adx_ff <= s1_a_ff * s1_dx_ff;
         s2_bdz_ff <= s1_b_ff * s1_dz_ff;
         s2_cdx_ff <= s1_c_ff * s1_dx_ff;
         s2_edz_ff <= s1_e_ff * s1_dz_ff;
         s2_dh1_ff <= s1_dh1_ff;
         s2_dh2_ff <= s1_dh2_ff;
         s2_h3_ff  <= s1_h3_ff;

         s3_det_ff <= WSUM_W'(s2_ae_ff) - WSUM_W'(s2_bc_ff);
         s3_w1_ff  <= WSUM_W'(s2_adx_ff) + WSUM_W'(s2_bdz_ff);
         s3_w2_ff  <= WSUM_W'(s2_cdx_ff) + WSUM_W'(s2_edz_ff);
         s3_dh1_ff <= s2_dh1_ff;
         s3_dh2_ff <= s2_dh2_ff;
         s3_h3_ff  <= s2_h3_ff;

         // weight times height delta, split into low and high partial products
         s4_p1l_ff <= $signed({1'b0, s3_w1_ff[SPLIT_W-1:0]}) * s3_dh1_ff;
         s4_p1h_ff <= $signed(s3_w1_ff[WSUM_W-1:SPLIT_W]) * s3_dh1_ff;
         s4_p2l_ff <= $signed({1'b0, s3_w2_ff[SPLIT_W-1:0]}) * s3_dh2_ff;
         s4_p2h_ff <= $signed(s3_w2_ff[WSUM_W-1:SPLIT_W]) * s3_dh2_ff;
         s4_det_ff <= s3_det_ff;
         s4_h3_ff  <= s3_h3_ff;

         s5_n1_ff  <= (NUM_W'(s4_p1h_ff) <<< SPLIT_W) + NUM_W'(s4_p1l_ff);
         s5_n2_ff  <= (NUM_W'(s4_p2h_ff) <<< SPLIT_W) + NUM_W'(s4_p2l_ff);
         s5_det_ff <= s4_det_ff;
         s5_h3_ff  <= s4_h3_ff;

         s6_num_ff <= s5_n1_ff + s5_n2_ff;
         s6_det_ff <= s5_det_ff;
         s6_dgn_ff <= (s5_det_ff == '0);
         s6_h3_ff  <= s5_h3_ff;

         // magnitudes and quotient sign
         s7_u_ff   <= s6_num_ff[NUM_W-1] ? NUM_W'(-s6_num_ff) : NUM_W'(s6_num_ff);
         s7_v_ff   <= s6_det_ff[WSUM_W-1] ? REM_W'(-s6_det_ff) : REM_W'(s6_det_ff);
         s7_neg_ff <= s6_num_ff[NUM_W-1] ^ s6_det_ff[WSUM_W-1];
         s7_dgn_ff <= s6_dgn_ff;
         s7_h3_ff  <= s6_h3_ff;

         s8_item_ff <= s8_item_in;
      end
   end

   assign out_valid = s8_valid_ff;
   assign out_item  = s8_item_ff;

endmodule

### rtl/tbh_div_cell.sv
// one restoring division cell: one quotient bit per beat
module tbh_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  tbh_pkg::div_item_type in_item,
   output logic                  out_valid,
   output tbh_pkg::div_item_type out_item
);
   import tbh_pkg::*;

   logic                 valid_ff;
   div_item_type         item_ff;
   div_item_type         item_in;
   logic [REM_W:0]       trial;
   logic [REM_W+1:0]     diff;
   logic                 fits;

   always_comb begin
      trial   = {in_item.rem, in_item.ubits[QUO_W-1]};
      diff    = {1'b0, trial} - {2'b00, in_item.dvs};
      fits    = ~diff[REM_W+1];
      item_in = in_item;
      item_in.rem   = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      item_in.ubits = {in_item.ubits[QUO_W-2:0], 1'b0};
      item_in.quo   = {in_item.quo[QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### rtl/tbh_back.sv
// final add, saturation and output register with skid stage
module tbh_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  tbh_pkg::div_item_type in_item,
   output logic                  en,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tbh_pkg::res_type      rsp_res
);
   import tbh_pkg::*;

   logic signed [RES_W-1:0] h3_ext, quo_ext, sum;
   res_type                 fin_in;
   res_type                 fin_ff;
   logic                    fin_valid_ff;
   res_type                 out_ff;
   logic                    out_valid_ff;
   res_type                 skid_ff;
   logic                    skid_valid_ff;
   logic                    push;
   logic                    take;

   always_comb begin
      h3_ext  = RES_W'(in_item.h3);
      quo_ext = $signed({2'b00, in_item.quo});
      sum     = in_item.neg ? (h3_ext - quo_ext) : (h3_ext + quo_ext);
      fin_in  = '0;
      priority if (in_item.degenerate) begin
         fin_in.degenerate = 1'b1;
      end else if (in_item.ovf) begin
         fin_in.height    = in_item.neg ? H_MIN : H_MAX;
         fin_in.saturated = 1'b1;
      end else if (sum > RES_W'(H_MAX)) begin
         fin_in.height    = H_MAX;
         fin_in.saturated = 1'b1;
      end else if (sum < RES_W'(H_MIN)) begin
         fin_in.height    = H_MIN;
         fin_in.saturated = 1'b1;
      end else begin
         fin_in.height = sum[COORD_W-1:0];
      end
   end

   assign en   = ~skid_valid_ff;
   assign push = fin_valid_ff & en;
   assign take = ~out_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            fin_valid_ff <= in_valid;
         end
         if (take) begin
            out_valid_ff  <= skid_valid_ff | push;
            skid_valid_ff <= 1'b0;
         end else if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_ff <= fin_in;
      end
      if (take) begin
         out_ff <= skid_valid_ff ? skid_ff : fin_ff;
      end else if (push) begin
         skid_ff <= fin_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_res   = out_ff;

endmodule

### rtl/triangle_barycentric_height.sv
// top level: barycentric height of a query point on a triangle
//
// req channel: one beat carries a triangle (three vertices of x, height, z)
// and a query point (x, z), all signed Q16.16. rsp channel: one beat per
// request with the interpolated height in tdata, and in tuser the degenerate
// flag (zero determinant, height 0) and the saturated flag (clipped result).
// Order of responses follows the order of requests.
// A new request is taken every cycle while the response side keeps up.
// Path from the request beat to rsp_tvalid: eight setup
// stages (differences, products, sums, split products, numerator, sign and
// range check), one cell per quotient bit in a chain of 34 division cells,
// one stage for the final add and saturation, and the output register.
// When rsp_tready is low the output register holds its beat and a skid
// stage catches the next one; the whole pipeline then freezes and req_tready
// drops until the skid stage drains. req_tready is a register output.
// Synchronous reset empties every stage and both output registers.
module triangle_barycentric_height (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // v1_x, v1_h, v1_z, v2_x, v2_h, v2_z, v3_x, v3_h, v3_z, query_x, query_z
   input  logic [351:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // height
   output logic [31:0]  rsp_tdata,
   // degenerate, saturated
   output logic [1:0]   rsp_tuser
);
   import tbh_pkg::*;

   tri_in_type   req_item;
   logic         en;
   logic         front_valid;
   div_item_type front_item;
   logic         cell_valid [DIV_CELLS+1];
   div_item_type cell_item  [DIV_CELLS+1];
   res_type      res;

   always_comb begin
      req_item.v1_x    = req_tdata[0*COORD_W +: COORD_W];
      req_item.v1_h    = req_tdata[1*COORD_W +: COORD_W];
      req_item.v1_z    = req_tdata[2*COORD_W +: COORD_W];
      req_item.v2_x    = req_tdata[3*COORD_W +: COORD_W];
      req_item.v2_h    = req_tdata[4*COORD_W +: COORD_W];
      req_item.v2_z    = req_tdata[5*COORD_W +: COORD_W];
      req_item.v3_x    = req_tdata[6*COORD_W +: COORD_W];
      req_item.v3_h    = req_tdata[7*COORD_W +: COORD_W];
      req_item.v3_z    = req_tdata[8*COORD_W +: COORD_W];
      req_item.query_x = req_tdata[9*COORD_W +: COORD_W];
      req_item.query_z = req_tdata[10*COORD_W +: COORD_W];
   end

   assign req_tready = en;

   tbh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   assign cell_valid[0] = front_valid;
   assign cell_item[0]  = front_item;

   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
      tbh_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cell_valid[i]),
         .in_item   (cell_item[i]),
         .out_valid (cell_valid[i+1]),
         .out_item  (cell_item[i+1])
      );
   end

   tbh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cell_valid[DIV_CELLS]),
      .in_item   (cell_item[DIV_CELLS]),
      .en        (en),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_res   (res)
   );

   assign rsp_tdata = res.height;
   assign rsp_tuser = {res.saturated, res.degenerate};

endmodule

### verif/triangle_barycentric_height_tb.sv
// testbench for triangle_barycentric_height with a wide-integer predictor
module triangle_barycentric_height_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tbh_pkg::*;

   localparam logic signed [COORD_W-1:0] ONE = 32'sh0001_0000;
   localparam int REQ_W = 11 * COORD_W;

   class height_board;
      res_type     expected_heights[$];
      int unsigned mismatches;

      // exact plane interpolation, one truncating divide, then clip
      function res_type interp_height(tri_in_type t);
         logic signed [127:0] x1, h1, z1, x2, h2, z2, x3, h3, z3, qx, qz;
         logic signed [127:0] a, b, c, e, dx, dz, det, w1, w2, num, sum, hi, lo;
         res_type r;
         x1 = $signed(t.v1_x);  h1 = $signed(t.v1_h);  z1 = $signed(t.v1_z);
         x2 = $signed(t.v2_x);  h2 = $signed(t.v2_h);  z2 = $signed(t.v2_z);
         x3 = $signed(t.v3_x);  h3 = $signed(t.v3_h);  z3 = $signed(t.v3_z);
         qx = $signed(t.query_x);
         qz = $signed(t.query_z);
         a = z2 - z3;
         b = x3 - x2;
         c = z3 - z1;
         e = x1 - x3;
         dx = qx - x3;
         dz = qz - z3;
         det = a * e - b * c;
         r.height = '0;
         r.degenerate = 1'b0;
         r.saturated = 1'b0;
         if (det == 0) begin
            r.degenerate = 1'b1;
            return r;
         end
         w1 = a * dx + b * dz;
         w2 = c * dx + e * dz;
         num = w1 * (h1 - h3) + w2 * (h2 - h3);
         sum = h3 + num / det;
         hi = H_MAX;
         lo = H_MIN;
         if (sum > hi) begin
            sum = hi;
            r.saturated = 1'b1;
         end else if (sum < lo) begin
            sum = lo;
            r.saturated = 1'b1;
         end
         r.height = sum[COORD_W-1:0];
         return r;
      endfunction

      function void record_query(tri_in_type t);
         expected_heights.push_back(interp_height(t));
      endfunction

      function void check_height(res_type got);
         res_type want;
         if (expected_heights.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp beat: height %0d degenerate %0b saturated %0b",
                        got.height, got.degenerate, got.saturated);
            return;
         end
         want = expected_heights.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected height %0d degenerate %0b saturated %0b,",
                        want.height, want.degenerate, want.saturated,
                        " got height %0d degenerate %0b saturated %0b",
                        got.height, got.degenerate, got.saturated);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [31:0]      rsp_tdata;
   logic [1:0]       rsp_tuser;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   height_board board = new();

   triangle_barycentric_height dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // struct keeps v1_x in the top bits, the bus keeps it in the bottom
   function automatic logic [REQ_W-1:0] reorder_fields(input logic [REQ_W-1:0] v);
      logic [REQ_W-1:0] r;
      for (int i = 0; i < 11; i++) r[i*COORD_W +: COORD_W] = v[(10-i)*COORD_W +: COORD_W];
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] spread(input int unsigned sh);
      logic signed [COORD_W-1:0] v;
      v = $urandom;
      return v >>> sh;
   endfunction

   function automatic tri_in_type random_query();
      tri_in_type         t;
      logic [REQ_W-1:0]   bits;
      logic signed [31:0] dx, dz;
      int unsigned        kind, sh, u, w;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 11; i++)
         bits[i*COORD_W +: COORD_W] = spread(kind == 6 ? 0 : $urandom_range(0, 31));
      t = bits;
      sh = $urandom_range(4, 22);
      case (kind)
         0, 1, 2, 3, 4, 5: begin
            // small terrain triangle, query mostly inside
            t.v3_x = spread(2);
            t.v3_z = spread(2);
            t.v1_x = t.v3_x + spread(sh);
            t.v1_z = t.v3_z + spread(sh);
            t.v2_x = t.v3_x + spread(sh);
            t.v2_z = t.v3_z + spread(sh);
            u = $urandom_range(0, 3);
            w = $urandom_range(0, 3);
            t.query_x = t.v3_x + ((t.v1_x - t.v3_x) >>> u) + ((t.v2_x - t.v3_x) >>> w)
                        + spread(sh + 2);
            t.query_z = t.v3_z + ((t.v1_z - t.v3_z) >>> u) + ((t.v2_z - t.v3_z) >>> w)
                        + spread(sh + 2);
         end
         7: begin
            // zero area: coincident points or a straight line
            dx = spread($urandom_range(2, 30));
            dz = spread($urandom_range(2, 30));
            case ($urandom_range(0, 2))
               0: begin
                  t.v2_x = t.v1_x;
                  t.v2_z = t.v1_z;
               end
               1: begin
                  t.v3_x = t.v1_x;
                  t.v3_z = t.v1_z;
               end
               default: begin
                  t.v2_x = t.v1_x + dx;
                  t.v2_z = t.v1_z + dz;
                  t.v3_x = t.v1_x + (dx <<< 1);
                  t.v3_z = t.v1_z + (dz <<< 1);
               end
            endcase
         end
         8: begin
            // steep tiny triangle with a distant query
            t.v1_x = t.v3_x + spread(24);
            t.v1_z = t.v3_z + spread(24);
            t.v2_x = t.v3_x + spread(24);
            t.v2_z = t.v3_z + spread(24);
            t.v1_h = spread(0);
            t.v2_h = spread(0);
            t.query_x = spread(0);
            t.query_z = spread(0);
         end
         default: ;
      endcase
      return t;
   endfunction

   task automatic send_query(input tri_in_type t);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= reorder_fields(t);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random(input int unsigned n);
      repeat (n) send_query(random_query());
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.record_query(reorder_fields(req_tdata));
         if (rsp_tvalid && rsp_tready)
            board.check_height(res_type'{$signed(rsp_tdata), rsp_tuser[0], rsp_tuser[1]});
      end
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      send_idle_pct = 34;
      recv_idle_pct = 71;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_query(tri_in_type'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
      send_query(tri_in_type'{ONE, 5*ONE, ONE, ONE, -3*ONE, ONE, ONE, 7, ONE, 0, 0});
      send_query(tri_in_type'{0, 0, 0, ONE, ONE, ONE, 2*ONE, -ONE, 2*ONE, ONE/2, ONE/3});
      send_query(tri_in_type'{0, ONE, 0, ONE, 2*ONE, 0, 0, 3*ONE, ONE, ONE/4, ONE/4});
      send_query(tri_in_type'{0, ONE, 0, ONE, 2*ONE, 0, 0, 3*ONE, ONE, 0, 0});
      send_query(tri_in_type'{0, ONE, 0, ONE, 2*ONE, 0, 0, 3*ONE, ONE, 0, ONE});
      send_query(tri_in_type'{0, ONE, 0, ONE, 2*ONE, 0, 0, 3*ONE, ONE, 10*ONE, -7*ONE});
      send_query(tri_in_type'{ONE, 2*ONE, 0, 0, ONE, 0, 0, 3*ONE, ONE, ONE/4, ONE/4});
      send_query(tri_in_type'{0, -5*ONE+3, 0, 3*ONE, -5*ONE+3, ONE, ONE, -5*ONE+3, 4*ONE,
                              ONE/7, 2*ONE});
      send_query(tri_in_type'{0, H_MAX, 0, 1, H_MAX, 0, 0, 0, 1, H_MIN, H_MIN});
      send_query(tri_in_type'{0, H_MAX, 0, 1, H_MAX, 0, 0, 0, 1, H_MAX, H_MAX});
      send_query(tri_in_type'{H_MAX, H_MAX, H_MAX, H_MAX, H_MAX, H_MAX, H_MAX, H_MAX, H_MAX,
                              H_MAX, H_MAX});
      send_query(tri_in_type'{H_MIN, H_MIN, H_MIN, H_MIN, H_MIN, H_MIN, H_MIN, H_MIN, H_MIN,
                              H_MIN, H_MIN});
      send_query(tri_in_type'{H_MIN, H_MAX, H_MIN, H_MAX, H_MIN, H_MIN, H_MIN, 0, H_MAX,
                              H_MAX, H_MAX});
      send_query(tri_in_type'{H_MAX, H_MIN, H_MAX, H_MIN, H_MAX, H_MAX, H_MAX, -1, H_MIN,
                              H_MIN, 0});
      send_query(tri_in_type'{32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'hf0f0_f0f0,
                              32'h3333_3333, 32'hcccc_cccc, 32'h00ff_00ff, 32'hff00_ff00,
                              32'h7f80_7f80, 32'h8001_8001, 32'h1234_5678});
      send_query(tri_in_type'{0, 0, 0, 1, 1, 0, 0, -1, 1, 12345, -678});
      send_query(tri_in_type'{-ONE, -2*ONE, -ONE, ONE, -4*ONE, -ONE, 0, -8*ONE, ONE, 0, 0});

      send_random(433);
      send_idle_pct = 71;
      recv_idle_pct = 34;
      send_random(433);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(434);
      req_tvalid <= 1'b0;

      while (board.expected_heights.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.mismatches == 0 && board.expected_heights.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
